// ===== hw/rtl/chbd_pkg.sv =====
`timescale 1ns / 1ps

package chbd_pkg;

    localparam int SIZE_BITS = 32;
    localparam int KEEP_BITS = 7;
    localparam logic [KEEP_BITS-1:0] LINE_KEEP = 7'd63;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_EARLY   = 2'd2;

    typedef enum logic [2:0] {
        PH_WS,
        PH_SIGN,
        PH_DIGITS,
        PH_PREFIX,
        PH_STOP,
        PH_PAYLOAD
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b0, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

// ===== hw/rtl/chbd_parse.sv =====
`timescale 1ns / 1ps

module chbd_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  chbd_pkg::in_item_t item,
    output chbd_pkg::result_t result,
    output logic              finished
);

    chbd_pkg::phase_t                   phase_reg, phase_next;
    logic [chbd_pkg::SIZE_BITS-1:0]     acc_reg, acc_next;
    logic [chbd_pkg::SIZE_BITS-1:0]     rem_reg, rem_next;
    logic [chbd_pkg::KEEP_BITS-1:0]     kept_reg, kept_next;
    logic                               neg_reg, neg_next;
    logic                               lone_reg, lone_next;
    logic                               fin_reg, fin_next;

    logic [7:0] c;
    logic [4:0] hd;
    logic       is_hex;
    logic       is_blank;
    logic       is_sign;
    logic       is_x;
    logic       keep_char;
    logic       line_done;
    logic [chbd_pkg::SIZE_BITS-1:0] acc_shift;

    assign c         = item.data_byte;
    assign hd        = chbd_pkg::hex_digit(c);
    assign is_hex    = !hd[4];
    assign is_blank  = (c == chbd_pkg::CH_SPACE) || (c == chbd_pkg::CH_TAB) ||
                       (c == chbd_pkg::CH_VT) || (c == chbd_pkg::CH_FF);
    assign is_sign   = (c == chbd_pkg::CH_PLUS) || (c == chbd_pkg::CH_MINUS);
    assign is_x      = (c == chbd_pkg::CH_X_LO) || (c == chbd_pkg::CH_X_UP);
    assign keep_char = (c != chbd_pkg::CH_LF) && (c != chbd_pkg::CH_CR) &&
                       (kept_reg < chbd_pkg::LINE_KEEP);
    // last payload byte of the chunk
    assign line_done = (rem_reg == chbd_pkg::SIZE_BITS'(1));

    // saturate once the top nibble is occupied
    assign acc_shift = (acc_reg[chbd_pkg::SIZE_BITS-1 -: 4] != 4'h0) ?
                       {chbd_pkg::SIZE_BITS{1'b1}} :
                       {acc_reg[chbd_pkg::SIZE_BITS-5:0], hd[3:0]};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step && !fin_reg && !item.stream_end) begin
            if (phase_reg == chbd_pkg::PH_PAYLOAD) begin
                if (line_done)
                    phase_next = chbd_pkg::PH_WS;
            end
            else if (c == chbd_pkg::CH_LF) begin
                if (kept_reg != '0 && !neg_reg && acc_reg != '0)
                    phase_next = chbd_pkg::PH_PAYLOAD;
                else
                    phase_next = chbd_pkg::PH_WS;
            end
            else if (keep_char) begin
                case (phase_reg)
                    chbd_pkg::PH_WS:
                        if (is_blank)
                            phase_next = chbd_pkg::PH_WS;
                        else if (is_sign)
                            phase_next = chbd_pkg::PH_SIGN;
                        else
                            phase_next = is_hex ? chbd_pkg::PH_DIGITS : chbd_pkg::PH_STOP;
                    chbd_pkg::PH_SIGN:
                        phase_next = is_hex ? chbd_pkg::PH_DIGITS : chbd_pkg::PH_STOP;
                    chbd_pkg::PH_DIGITS:
                        if (lone_reg && is_x)
                            phase_next = chbd_pkg::PH_PREFIX;
                        else if (!is_hex)
                            phase_next = chbd_pkg::PH_STOP;
                    chbd_pkg::PH_PREFIX:
                        phase_next = is_hex ? chbd_pkg::PH_DIGITS : chbd_pkg::PH_STOP;
                    default:
                        phase_next = phase_reg;
                endcase
            end
        end
    end

    // datapath and result
    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        kept_next = kept_reg;
        neg_next  = neg_reg;
        lone_next = lone_reg;
        fin_next  = fin_reg;
        result    = '0;
        if (step && !fin_reg) begin
            if (item.stream_end) begin
                result.valid     = 1'b1;
                result.item.kind = chbd_pkg::KIND_EARLY;
                fin_next         = 1'b1;
            end
            else if (phase_reg == chbd_pkg::PH_PAYLOAD) begin
                result.valid         = 1'b1;
                result.item.kind     = chbd_pkg::KIND_PAYLOAD;
                result.item.out_byte = c;
                rem_next             = rem_reg - chbd_pkg::SIZE_BITS'(1);
                if (line_done) begin
                    acc_next  = '0;
                    kept_next = '0;
                    neg_next  = 1'b0;
                    lone_next = 1'b0;
                end
            end
            else if (c == chbd_pkg::CH_LF) begin
                if (kept_reg != '0) begin
                    if (neg_reg || acc_reg == '0) begin
                        result.valid     = 1'b1;
                        result.item.kind = chbd_pkg::KIND_END;
                        fin_next         = 1'b1;
                    end
                    else begin
                        rem_next = acc_reg;
                    end
                end
                acc_next  = '0;
                kept_next = '0;
                neg_next  = 1'b0;
                lone_next = 1'b0;
            end
            else if (keep_char) begin
                kept_next = kept_reg + chbd_pkg::KEEP_BITS'(1);
                case (phase_reg)
                    chbd_pkg::PH_WS, chbd_pkg::PH_SIGN:
                        if (phase_reg == chbd_pkg::PH_WS && is_sign)
                            neg_next = (c == chbd_pkg::CH_MINUS);
                        else if (!(phase_reg == chbd_pkg::PH_WS && is_blank) && is_hex) begin
                            acc_next  = chbd_pkg::SIZE_BITS'(hd[3:0]);
                            lone_next = (hd[3:0] == 4'h0);
                        end
                    chbd_pkg::PH_DIGITS:
                        if (lone_reg && is_x)
                            lone_next = 1'b0;
                        else if (is_hex) begin
                            lone_next = 1'b0;
                            acc_next  = acc_shift;
                        end
                    chbd_pkg::PH_PREFIX:
                        if (is_hex)
                            acc_next = chbd_pkg::SIZE_BITS'(hd[3:0]);
                    default:
                        acc_next = acc_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= chbd_pkg::PH_WS;
            acc_reg   <= '0;
            rem_reg   <= '0;
            kept_reg  <= '0;
            neg_reg   <= 1'b0;
            lone_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            kept_reg  <= kept_next;
            neg_reg   <= neg_next;
            lone_reg  <= lone_next;
            fin_reg   <= fin_next;
        end
    end

    assign finished = fin_reg;

endmodule

// ===== hw/rtl/chbd_out.sv =====
`timescale 1ns / 1ps

module chbd_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  chbd_pkg::result_t  result,
    output logic               out_valid,
    input  logic               out_ready,
    output chbd_pkg::out_item_t out_data
);

    logic                valid_reg;
    chbd_pkg::out_item_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= result.valid;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load && result.valid)
            data_reg <= result.item;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps
// Each byte's result passes through the input register, then the result register;
// the input register holds its byte while the result register waits for out_ready.
// Throughput: one byte per cycle unless out_ready stalls; the parser updates once per byte.
// Reset: asynchronous, clears the parser state and both valid flags; the
// decoder restarts on a fresh size line.

module http_chunked_body_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  chbd_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output chbd_pkg::out_item_t out_data
);

    logic               in_valid_reg;
    chbd_pkg::in_item_t in_data_reg;
    logic               advance;
    chbd_pkg::result_t  result;
    logic               finished;

    // stage moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_data_reg <= in_data;
    end

    chbd_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (in_data_reg),
        .result   (result),
        .finished (finished)
    );

    chbd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // an end or error transaction is only ever shown after the parser has latched finish
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != chbd_pkg::KIND_PAYLOAD |-> finished)
        else $error("terminal result without finish");

    // once finished, the parser never produces another result
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(finished) |-> !result.valid)
        else $error("result after finish");

    // terminal results carry no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != chbd_pkg::KIND_PAYLOAD |-> out_data.out_byte == 8'h00)
        else $error("terminal result with non-zero byte");

    // the input stage can always take a transaction when empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("empty input stage stalled");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 1000;
    localparam int CALM_TAIL   = 40;
    localparam longint unsigned SIZE_CAP = (64'd1 << chbd_pkg::SIZE_BITS) - 1;
    localparam logic [7:0] BLANKS [4] = '{chbd_pkg::CH_SPACE, chbd_pkg::CH_TAB,
                                          chbd_pkg::CH_VT, chbd_pkg::CH_FF};

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    chbd_pkg::in_item_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    chbd_pkg::out_item_t out_data;

    http_chunked_body_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    chbd_pkg::in_item_t  body_bytes[$];
    chbd_pkg::out_item_t expected_decoded[$];
    int        total_bytes;
    int        accepted_bytes = 0;
    int        errors = 0;
    int        stall_cycles = 0;
    logic      in_fire = 1'b0;
    int        in_gap = 0;
    int        out_gap = 0;
    int        in_gap_pct = 10;
    int        out_gap_pct = 10;

    // decoder state as the predictor sees it
    chbd_pkg::phase_t ph;
    longint unsigned  size_acc;
    longint unsigned  bytes_left;
    logic [6:0]       kept;
    logic             neg;
    logic             lone_zero;
    logic             done;

    function automatic int nibble_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - 8'h30);
        if (c >= "a" && c <= "f")
            return int'(c - 8'h57);
        if (c >= "A" && c <= "F")
            return int'(c - 8'h37);
        return -1;
    endfunction

    task automatic new_line();
        ph        = chbd_pkg::PH_WS;
        size_acc  = 0;
        kept      = '0;
        neg       = 1'b0;
        lone_zero = 1'b0;
    endtask

    task automatic start_digits(input logic [7:0] c);
        int d;
        d = nibble_value(c);
        if (d < 0)
            ph = chbd_pkg::PH_STOP;
        else
        begin
            size_acc  = 64'(d);
            lone_zero = (d == 0);
            ph        = chbd_pkg::PH_DIGITS;
        end
    endtask

    task automatic take_char(input logic [7:0] c);
        int d;
        d = nibble_value(c);
        case (ph)
            chbd_pkg::PH_WS:
            begin
                if (c == chbd_pkg::CH_PLUS || c == chbd_pkg::CH_MINUS)
                begin
                    neg = (c == chbd_pkg::CH_MINUS);
                    ph  = chbd_pkg::PH_SIGN;
                end
                else if (c != chbd_pkg::CH_SPACE && c != chbd_pkg::CH_TAB &&
                         c != chbd_pkg::CH_VT && c != chbd_pkg::CH_FF)
                    start_digits(c);
            end
            chbd_pkg::PH_SIGN:
                start_digits(c);
            chbd_pkg::PH_DIGITS:
            begin
                if (lone_zero && (c == chbd_pkg::CH_X_LO || c == chbd_pkg::CH_X_UP))
                begin
                    lone_zero = 1'b0;
                    ph        = chbd_pkg::PH_PREFIX;
                end
                else if (d < 0)
                    ph = chbd_pkg::PH_STOP;
                else
                begin
                    lone_zero = 1'b0;
                    // saturate rather than wrap
                    if (size_acc > (SIZE_CAP - 64'(d)) / 16)
                        size_acc = SIZE_CAP;
                    else
                        size_acc = size_acc * 16 + 64'(d);
                end
            end
            chbd_pkg::PH_PREFIX:
            begin
                if (d < 0)
                    ph = chbd_pkg::PH_STOP;
                else
                begin
                    size_acc = 64'(d);
                    ph       = chbd_pkg::PH_DIGITS;
                end
            end
            default: ;
        endcase
    endtask

    task automatic decode_step(input chbd_pkg::in_item_t it);
        chbd_pkg::out_item_t r;
        logic                emit;
        r    = '0;
        emit = 1'b0;
        if (done)
            emit = 1'b0;
        else if (it.stream_end)
        begin
            r.kind = chbd_pkg::KIND_EARLY;
            emit   = 1'b1;
            done   = 1'b1;
        end
        else if (ph == chbd_pkg::PH_PAYLOAD)
        begin
            r.out_byte = it.data_byte;
            r.kind     = chbd_pkg::KIND_PAYLOAD;
            emit       = 1'b1;
            bytes_left--;
            if (bytes_left == 0)
                new_line();
        end
        else if (it.data_byte == chbd_pkg::CH_LF)
        begin
            if (kept == 0)
                new_line();
            else if (neg || size_acc == 0)
            begin
                new_line();
                r.kind = chbd_pkg::KIND_END;
                emit   = 1'b1;
                done   = 1'b1;
            end
            else
            begin
                bytes_left = size_acc;
                new_line();
                ph = chbd_pkg::PH_PAYLOAD;
            end
        end
        else if (it.data_byte != chbd_pkg::CH_CR && kept < chbd_pkg::LINE_KEEP)
        begin
            kept++;
            take_char(it.data_byte);
        end
        if (emit)
            expected_decoded.push_back(r);
    endtask

    // stimulus building
    task automatic put_byte(input logic [7:0] b);
        chbd_pkg::in_item_t it;
        it.data_byte  = b;
        it.stream_end = 1'b0;
        body_bytes.push_back(it);
    endtask

    task automatic put_close();
        chbd_pkg::in_item_t it;
        it.data_byte  = 8'($urandom_range(255));
        it.stream_end = 1'b1;
        body_bytes.push_back(it);
    endtask

    task automatic put_crlf();
        put_byte(chbd_pkg::CH_CR);
        put_byte(chbd_pkg::CH_LF);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    // size-line characters, with stray CRs that the parser must drop
    task automatic put_line_byte(input logic [7:0] b);
        if ($urandom_range(9) == 0)
            put_byte(chbd_pkg::CH_CR);
        put_byte(b);
    endtask

    task automatic put_line_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_line_byte(s[i]);
    endtask

    task automatic put_payload(input int n);
        repeat (n)
            put_byte(8'($urandom_range(255)));
    endtask

    task automatic put_chunk(input int n);
        string      digits;
        logic [7:0] b;
        if ($urandom_range(5) == 0)
            put_crlf();
        digits = $sformatf("%0h", n);
        if ($urandom_range(1))
            digits = digits.toupper();
        case ($urandom_range(7))
            1: put_line_text("0x");
            2: put_line_text("0X");
            3: put_line_text("00");
            4: put_line_text("+");
            5: put_line_text("+0x");
            6: repeat ($urandom_range(4, 1)) put_line_byte(BLANKS[2'($urandom_range(3))]);
            default: ;
        endcase
        put_line_text(digits);
        case ($urandom_range(5))
            0: put_line_text(";name=val");
            1: put_line_text("  ");
            2:
            begin
                // runs well past the kept length
                put_line_byte(chbd_pkg::CH_SPACE);
                repeat (70)
                begin
                    b = 8'($urandom_range(255));
                    put_line_byte(b == chbd_pkg::CH_LF ? 8'h2E : b);
                end
            end
            default: ;
        endcase
        if ($urandom_range(3) == 0)
            put_byte(chbd_pkg::CH_LF);
        else
            put_crlf();
        put_payload(n);
        case ($urandom_range(5))
            0: put_byte(chbd_pkg::CH_LF);
            1: ;
            default: put_crlf();
        endcase
    endtask

    task automatic end_body();
        logic line_case;
        line_case = 1'b1;
        case ($urandom_range(11))
            0: put_line_text("0");
            1: put_line_text("-7");
            2: put_line_text("-FFFFFFFFFFFF");
            3: put_line_text("0xg");
            4: put_line_text("0x");
            5:
            begin
                put_line_byte(chbd_pkg::CH_SPACE);
                put_line_byte(chbd_pkg::CH_TAB);
                put_line_byte(chbd_pkg::CH_FF);
            end
            6: put_line_text("+");
            7: put_line_text("zz;");
            8:
            begin
                // the digit falls beyond the kept length
                repeat (chbd_pkg::LINE_KEEP) put_line_byte(chbd_pkg::CH_SPACE);
                put_line_text("5");
            end
            9: put_line_text("00x5");
            10:
            begin
                line_case = 1'b0;
                put_close();
            end
            default:
            begin
                // saturated size, then the link drops mid-chunk
                line_case = 1'b0;
                put_text("123456789ABCDEF");
                put_crlf();
                put_payload(20);
                put_close();
            end
        endcase
        if (line_case)
            put_crlf();
        // all of this must be ignored
        repeat (6)
        begin
            if ($urandom_range(2) == 0)
                put_close();
            else
                put_byte(8'($urandom_range(255)));
        end
        put_close();
        put_text("3");
        put_crlf();
        put_byte(8'hA5);
    endtask

    // input driver
    always @(negedge clk)
    begin : drive_in
        chbd_pkg::in_item_t nxt_data;
        logic               nxt_valid;
        logic               calm;
        nxt_valid = in_valid;
        nxt_data  = in_data;
        calm      = (accepted_bytes + CALM_TAIL >= total_bytes);
        if (rst_n && (!in_valid || in_fire))
        begin
            nxt_valid = 1'b0;
            if (in_gap > 0)
                in_gap--;
            else if (body_bytes.size() != 0)
            begin
                if (!calm && $urandom_range(99) < in_gap_pct)
                    in_gap = $urandom_range(11, 0);
                else
                begin
                    nxt_valid = 1'b1;
                    nxt_data  = body_bytes.pop_front();
                    if ($urandom_range(49) == 0)
                        case ($urandom_range(2))
                            0: in_gap_pct = 0;
                            1: in_gap_pct = 8;
                            default: in_gap_pct = 35;
                        endcase
                end
            end
        end
        in_valid <= nxt_valid;
        in_data  <= nxt_data;
    end

    // output back-pressure
    always @(negedge clk)
    begin : drive_out
        logic nxt_ready;
        logic calm;
        calm = (accepted_bytes + CALM_TAIL >= total_bytes);
        if (out_gap > 0)
        begin
            out_gap--;
            nxt_ready = 1'b0;
        end
        else if (!calm && $urandom_range(99) < out_gap_pct)
        begin
            out_gap   = $urandom_range(11, 0);
            nxt_ready = 1'b0;
        end
        else
        begin
            nxt_ready = 1'b1;
            if ($urandom_range(49) == 0)
                case ($urandom_range(2))
                    0: out_gap_pct = 0;
                    1: out_gap_pct = 8;
                    default: out_gap_pct = 35;
                endcase
        end
        out_ready <= nxt_ready;
    end

    // monitor and checker
    always @(posedge clk)
    begin : watch
        chbd_pkg::out_item_t want;
        in_fire <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_decoded.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: unexpected transaction byte %02h kind %0d",
                                 $time, out_data.out_byte, out_data.kind);
                    errors++;
                end
                else
                begin
                    want = expected_decoded.pop_front();
                    if (out_data.out_byte !== want.out_byte || out_data.kind !== want.kind)
                    begin
                        if (errors < 10)
                            $display({"%0t: mismatch, expected byte %02h kind %0d, ",
                                      "got byte %02h kind %0d"},
                                     $time, want.out_byte, want.kind,
                                     out_data.out_byte, out_data.kind);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                decode_step(in_data);
                accepted_bytes++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        new_line();
        bytes_left = 0;
        done       = 1'b0;

        // blank lines, prefix, sign, blanks, extension, LF and CR as payload
        put_crlf();
        put_byte(chbd_pkg::CH_LF);
        put_text("0X2");
        put_crlf();
        put_byte(8'hFF);
        put_byte(8'h00);
        put_crlf();
        put_text("+1");
        put_byte(chbd_pkg::CH_LF);
        put_byte(chbd_pkg::CH_LF);
        put_byte(chbd_pkg::CH_TAB);
        put_byte(chbd_pkg::CH_VT);
        put_byte(chbd_pkg::CH_FF);
        put_text("1;x");
        put_crlf();
        put_byte(chbd_pkg::CH_CR);
        put_crlf();

        // large chunks only early on, so the total stays near the target
        while (body_bytes.size() < 340)
        begin
            if (body_bytes.size() < 150 && $urandom_range(9) == 0)
                put_chunk(255 + int'($urandom_range(1)));
            else if ($urandom_range(4) == 0)
                put_chunk($urandom_range(40, 13));
            else
                put_chunk($urandom_range(12, 1));
        end
        end_body();
        total_bytes = body_bytes.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_bytes != total_bytes)
            @(negedge clk);
        while (expected_decoded.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
